FILE: hw/rtl/clr_pkg.sv
// Shared constants and code types for the clipped line rasterizer.
// Used by clr_front, clr_queue, clr_back and clipped_line_rasterizer.
`default_nettype none

package clr_pkg;

  localparam int COORD_BITS_DEF = 12;  // default coordinate width
  localparam int CLIP_MIN_BITS  = 12;  // clip registers hold at least this many bits
  localparam int DIM_BITS       = 12;  // written width of image_width / image_height
  localparam int DIM_REG_BITS   = 13;  // stored width, holds the reset size of 2048
  localparam int ADDR_BITS      = 22;
  localparam int COLOR_BITS     = 32;
  localparam int CFG_DATA_BITS  = 32;
  localparam int CFG_INDEX_BITS = 3;
  localparam int QUEUE_DEPTH    = 4;   // power of two

  localparam int CLIP_X_MIN_RST = 0;
  localparam int CLIP_X_MAX_RST = 2047;
  localparam int CLIP_Y_MIN_RST = 0;
  localparam int CLIP_Y_MAX_RST = 2047;
  localparam int IMAGE_DIM_RST  = 2048;

  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_TICK = 1'b1
  } mode_e;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_CLIP_X_MIN  = 3'd0,
    REG_CLIP_X_MAX  = 3'd1,
    REG_CLIP_Y_MIN  = 3'd2,
    REG_CLIP_Y_MAX  = 3'd3,
    REG_IMAGE_WIDTH = 3'd4,
    REG_IMAGE_HEIGHT = 3'd5,
    REG_INK_COLOR   = 3'd6
  } cfg_reg_e;

endpackage

`default_nettype wire

FILE: hw/rtl/clr_front.sv
// Front end: input register that classifies each beat and precomputes
// line setup (absolute deltas, step directions). Depends on clr_pkg.
`default_nettype none

module clr_front #(
  parameter int COORD_BITS = clr_pkg::COORD_BITS_DEF,
  parameter int ENTRY_BITS = 6 * COORD_BITS + 3
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output      logic                         in_stall_o,
  input  wire logic                         mode_i,
  input  wire logic signed [COORD_BITS-1:0] start_x_i,
  input  wire logic signed [COORD_BITS-1:0] start_y_i,
  input  wire logic signed [COORD_BITS-1:0] finish_x_i,
  input  wire logic signed [COORD_BITS-1:0] finish_y_i,
  output      logic                         q_valid_o,
  input  wire logic                         q_stall_i,
  output      logic [ENTRY_BITS-1:0]        q_entry_o
);
  import clr_pkg::*;

  localparam int C = COORD_BITS;

  typedef struct packed {
    logic                is_load;
    logic signed [C-1:0] x0;
    logic signed [C-1:0] y0;
    logic signed [C-1:0] x1;
    logic signed [C-1:0] y1;
    logic [C-1:0]        dx;
    logic [C-1:0]        dy;
    logic                sx_neg;
    logic                sy_neg;
  } entry_t;

  logic                valid_q;
  entry_t              entry_q, entry_d;
  logic signed [C:0]   diff_x, diff_y;
  logic                x_lt, y_lt;
  logic                accept;

  assign in_stall_o = valid_q && q_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    diff_x = {finish_x_i[C-1], finish_x_i} - {start_x_i[C-1], start_x_i};
    diff_y = {finish_y_i[C-1], finish_y_i} - {start_y_i[C-1], start_y_i};
    x_lt   = start_x_i < finish_x_i;
    y_lt   = start_y_i < finish_y_i;
    entry_d.is_load = (mode_e'(mode_i) == MODE_LOAD);
    entry_d.x0      = start_x_i;
    entry_d.y0      = start_y_i;
    entry_d.x1      = finish_x_i;
    entry_d.y1      = finish_y_i;
    entry_d.dx      = x_lt ? C'(diff_x) : C'(-diff_x);
    entry_d.dy      = y_lt ? C'(diff_y) : C'(-diff_y);
    entry_d.sx_neg  = !x_lt;
    entry_d.sy_neg  = !y_lt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      entry_q <= entry_d;
    end
  end

  assign q_valid_o = valid_q;
  assign q_entry_o = ENTRY_BITS'(entry_q);

endmodule

`default_nettype wire

FILE: hw/rtl/clr_queue.sv
// Short command queue between front and back end, valid/stall on both sides.
// Depends on clr_pkg for the default depth.
`default_nettype none

module clr_queue #(
  parameter int DATA_BITS = 8,
  parameter int DEPTH     = clr_pkg::QUEUE_DEPTH
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 wr_valid_i,
  output      logic                 wr_stall_o,
  input  wire logic [DATA_BITS-1:0] wr_data_i,
  output      logic                 rd_valid_o,
  input  wire logic                 rd_stall_i,
  output      logic [DATA_BITS-1:0] rd_data_o
);
  import clr_pkg::*;

  localparam int PTR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [DATA_BITS-1:0] mem_q [DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_BITS-1:0]  count_q, count_d;
  logic                 push, pop;

  assign wr_stall_o = (count_q == CNT_BITS'(DEPTH));
  assign rd_valid_o = (count_q != '0);
  assign push       = wr_valid_i && !wr_stall_o;
  assign pop        = rd_valid_o && !rd_stall_i;
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_BITS'(DEPTH))
    else $error("queue count past depth");

  a_count_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count missed a push");

  a_count_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> (count_q == $past(count_q) - 1'b1))
    else $error("queue count missed a pop");

endmodule

`default_nettype wire

FILE: hw/rtl/clr_back.sv
// Back end: Bresenham stepper, clip/bounds test, address multiply and the
// output register, plus the configuration registers. Depends on clr_pkg.
`default_nettype none

module clr_back #(
  parameter int COORD_BITS = clr_pkg::COORD_BITS_DEF,
  parameter int ENTRY_BITS = 6 * COORD_BITS + 3
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [clr_pkg::CFG_INDEX_BITS-1:0]   cfg_index_i,
  input  wire logic [clr_pkg::CFG_DATA_BITS-1:0]    cfg_data_i,
  input  wire logic                                 q_valid_i,
  output      logic                                 q_stall_o,
  input  wire logic [ENTRY_BITS-1:0]                q_entry_i,
  output      logic                                 out_valid_o,
  input  wire logic                                 out_stall_i,
  output      logic signed [COORD_BITS-1:0]         pixel_x_o,
  output      logic signed [COORD_BITS-1:0]         pixel_y_o,
  output      logic [clr_pkg::ADDR_BITS-1:0]        pixel_address_o,
  output      logic                                 write_enable_o,
  output      logic [clr_pkg::COLOR_BITS-1:0]       color_o,
  output      logic                                 last_o
);
  import clr_pkg::*;

  localparam int C         = COORD_BITS;
  localparam int E         = COORD_BITS + 2;
  localparam int CLIP_BITS = (C > CLIP_MIN_BITS) ? C : CLIP_MIN_BITS;
  localparam int CMP_BITS  = ((C > DIM_REG_BITS) ? C : DIM_REG_BITS) + 1;
  localparam int PROD_BITS = C + DIM_REG_BITS;

  typedef struct packed {
    logic                is_load;
    logic signed [C-1:0] x0;
    logic signed [C-1:0] y0;
    logic signed [C-1:0] x1;
    logic signed [C-1:0] y1;
    logic [C-1:0]        dx;
    logic [C-1:0]        dy;
    logic                sx_neg;
    logic                sy_neg;
  } entry_t;

  // configuration
  logic signed [CLIP_BITS-1:0] clip_x_min_q, clip_x_max_q, clip_y_min_q, clip_y_max_q;
  logic [DIM_REG_BITS-1:0]     width_q, height_q;
  logic [COLOR_BITS-1:0]       ink_q;
  logic signed [CLIP_BITS-1:0] cfg_coord;

  assign cfg_coord = CLIP_BITS'($signed(cfg_data_i[C-1:0]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_x_min_q <= CLIP_BITS'(CLIP_X_MIN_RST);
      clip_x_max_q <= CLIP_BITS'(CLIP_X_MAX_RST);
      clip_y_min_q <= CLIP_BITS'(CLIP_Y_MIN_RST);
      clip_y_max_q <= CLIP_BITS'(CLIP_Y_MAX_RST);
      width_q      <= DIM_REG_BITS'(IMAGE_DIM_RST);
      height_q     <= DIM_REG_BITS'(IMAGE_DIM_RST);
      ink_q        <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_CLIP_X_MIN:   clip_x_min_q <= cfg_coord;
        REG_CLIP_X_MAX:   clip_x_max_q <= cfg_coord;
        REG_CLIP_Y_MIN:   clip_y_min_q <= cfg_coord;
        REG_CLIP_Y_MAX:   clip_y_max_q <= cfg_coord;
        REG_IMAGE_WIDTH:  width_q  <= {1'b0, cfg_data_i[DIM_BITS-1:0]};
        REG_IMAGE_HEIGHT: height_q <= {1'b0, cfg_data_i[DIM_BITS-1:0]};
        REG_INK_COLOR:    ink_q    <= cfg_data_i[COLOR_BITS-1:0];
        default: ;
      endcase
    end
  end

  // pipeline enables, from the output back
  logic out_en, s2_en, s1_en, take;
  logic s1_valid_q, s2_valid_q, out_valid_q;

  assign out_en    = !out_valid_q || !out_stall_i;
  assign s2_en     = !s2_valid_q || out_en;
  assign s1_en     = !s1_valid_q || s2_en;
  assign q_stall_o = !s1_en;
  assign take      = q_valid_i && s1_en;

  // line state
  entry_t              entry;
  logic signed [C-1:0] cur_x_q, cur_y_q, end_x_q, end_y_q;
  logic [C-1:0]        dx_q, dy_q;
  logic                sx_neg_q, sy_neg_q, active_q;
  logic signed [E-1:0] err_q;
  logic signed [E:0]   e2, dx_w, dy_w;
  logic signed [E-1:0] dx_e, dy_e;
  logic                go_x, go_y, is_last, emit;
  logic signed [C-1:0] step_x, step_y;

  assign entry   = entry_t'(q_entry_i);
  assign is_last = (cur_x_q == end_x_q) && (cur_y_q == end_y_q);
  assign emit    = take && !entry.is_load && active_q;

  always_comb begin
    e2     = {err_q, 1'b0};
    dx_w   = $signed({3'b000, dx_q});
    dy_w   = $signed({3'b000, dy_q});
    dx_e   = $signed({2'b00, dx_q});
    dy_e   = $signed({2'b00, dy_q});
    go_x   = e2 > -dy_w;
    go_y   = e2 < dx_w;
    step_x = sx_neg_q ? '1 : C'(1);
    step_y = sy_neg_q ? '1 : C'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      end_x_q  <= '0;
      end_y_q  <= '0;
      dx_q     <= '0;
      dy_q     <= '0;
      sx_neg_q <= 1'b0;
      sy_neg_q <= 1'b0;
      err_q    <= '0;
      active_q <= 1'b0;
    end else if (take && entry.is_load) begin
      cur_x_q  <= entry.x0;
      cur_y_q  <= entry.y0;
      end_x_q  <= entry.x1;
      end_y_q  <= entry.y1;
      dx_q     <= entry.dx;
      dy_q     <= entry.dy;
      sx_neg_q <= entry.sx_neg;
      sy_neg_q <= entry.sy_neg;
      err_q    <= $signed({2'b00, entry.dx}) - $signed({2'b00, entry.dy});
      active_q <= 1'b1;
    end else if (emit) begin
      if (is_last) begin
        active_q <= 1'b0;
      end else begin
        err_q   <= err_q - (go_x ? dy_e : '0) + (go_y ? dx_e : '0);
        cur_x_q <= go_x ? cur_x_q + step_x : cur_x_q;
        cur_y_q <= go_y ? cur_y_q + step_y : cur_y_q;
      end
    end
  end

  // stage 1: pixel picked off the stepper
  logic signed [C-1:0] s1_x_q, s1_y_q;
  logic                s1_last_q;

  // stage 2: clip test and row product
  logic signed [C-1:0]     s2_x_q, s2_y_q;
  logic                    s2_last_q, s2_inside_q, in_box;
  logic [ADDR_BITS-1:0]    s2_prod_q;
  logic [PROD_BITS-1:0]    prod;
  logic signed [CMP_BITS-1:0] xc, yc, wc, hc;

  always_comb begin
    xc = CMP_BITS'(s1_x_q);
    yc = CMP_BITS'(s1_y_q);
    wc = $signed({{(CMP_BITS - DIM_REG_BITS){1'b0}}, width_q});
    hc = $signed({{(CMP_BITS - DIM_REG_BITS){1'b0}}, height_q});
    in_box = (xc >= CMP_BITS'(clip_x_min_q)) && (xc <= CMP_BITS'(clip_x_max_q)) &&
             (yc >= CMP_BITS'(clip_y_min_q)) && (yc <= CMP_BITS'(clip_y_max_q)) &&
             (xc >= CMP_BITS'(0)) && (yc >= CMP_BITS'(0)) && (xc < wc) && (yc < hc);
    prod   = PROD_BITS'($unsigned(s1_y_q)) * PROD_BITS'(width_q);
  end

  // output register
  logic signed [C-1:0]  px_q, py_q;
  logic [ADDR_BITS-1:0] addr_q;
  logic                 we_q, last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid_q <= emit;
      end
      if (s2_en) begin
        s2_valid_q <= s1_valid_q;
      end
      if (out_en) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      s1_x_q    <= cur_x_q;
      s1_y_q    <= cur_y_q;
      s1_last_q <= is_last;
    end
    if (s2_en && s1_valid_q) begin
      s2_x_q      <= s1_x_q;
      s2_y_q      <= s1_y_q;
      s2_last_q   <= s1_last_q;
      s2_inside_q <= in_box;
      s2_prod_q   <= ADDR_BITS'(prod);
    end
    if (out_en && s2_valid_q) begin
      px_q   <= s2_x_q;
      py_q   <= s2_y_q;
      last_q <= s2_last_q;
      we_q   <= s2_inside_q;
      addr_q <= s2_inside_q ? s2_prod_q + ADDR_BITS'($unsigned(s2_x_q)) : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pixel_x_o       = px_q;
  assign pixel_y_o       = py_q;
  assign pixel_address_o = addr_q;
  assign write_enable_o  = we_q;
  assign last_o          = last_q;
  assign color_o         = ink_q;

  a_last_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && is_last) |=> !active_q)
    else $error("engine still active after the end pixel");

  a_clipped_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !we_q) |-> (addr_q == '0))
    else $error("clipped pixel carries a nonzero address");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=>
      (out_valid_q && $stable(px_q) && $stable(py_q) && $stable(addr_q)))
    else $error("stalled pixel beat changed");

endmodule

`default_nettype wire

FILE: hw/rtl/clipped_line_rasterizer.sv
// Top level of the clipped line rasterizer: front end, command queue and back end.
// Depends on clr_pkg, clr_front, clr_queue and clr_back.
//
// Bresenham line engine with a clip box. A load beat (mode 0) latches both end
// points and gives no pixel; each tick beat (mode 1) then gives one pixel: its x
// and y, the linear address y*image_width+x and a write enable that is set only
// inside the inclusive clip box and inside the image (address is 0 otherwise).
// The end point carries last and the engine then idles; a tick while idle gives
// nothing, and a new load restarts the engine at once. Throughput is one beat
// per clock on both sides when nothing stalls: the stepper advances one pixel
// per cycle, its update being an error add/subtract and two compares. A tick
// passes the input register, queue, stepper stage, clip/multiply stage and
// output register. A four-entry queue lets the input side keep accepting while
// the pixel side is stalled. Clip, image size and ink color are read live;
// write them only with no beat in flight. color_o follows ink_color directly.
`default_nettype none

module clipped_line_rasterizer #(
  parameter int COORD_BITS = clr_pkg::COORD_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // configuration writes
  input  wire logic                                cfg_we_i,
  input  wire logic [clr_pkg::CFG_INDEX_BITS-1:0]  cfg_index_i,
  input  wire logic [clr_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  // command beats
  input  wire logic                                in_valid_i,
  output      logic                                in_stall_o,
  input  wire logic                                mode_i,
  input  wire logic signed [COORD_BITS-1:0]        start_x_i,
  input  wire logic signed [COORD_BITS-1:0]        start_y_i,
  input  wire logic signed [COORD_BITS-1:0]        finish_x_i,
  input  wire logic signed [COORD_BITS-1:0]        finish_y_i,
  // pixel beats
  output      logic                                out_valid_o,
  input  wire logic                                out_stall_i,
  output      logic signed [COORD_BITS-1:0]        pixel_x_o,
  output      logic signed [COORD_BITS-1:0]        pixel_y_o,
  output      logic [clr_pkg::ADDR_BITS-1:0]       pixel_address_o,
  output      logic                                write_enable_o,
  output      logic [clr_pkg::COLOR_BITS-1:0]      color_o,
  output      logic                                last_o
);
  import clr_pkg::*;

  // queue entry: load flag, four end point coordinates, two deltas, two step signs
  localparam int ENTRY_BITS = 6 * COORD_BITS + 3;

  logic                  fq_valid, fq_stall;
  logic [ENTRY_BITS-1:0] fq_entry;
  logic                  qb_valid, qb_stall;
  logic [ENTRY_BITS-1:0] qb_entry;

  // classify and set up each command beat
  clr_front #(
    .COORD_BITS (COORD_BITS),
    .ENTRY_BITS (ENTRY_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mode_i     (mode_i),
    .start_x_i  (start_x_i),
    .start_y_i  (start_y_i),
    .finish_x_i (finish_x_i),
    .finish_y_i (finish_y_i),
    .q_valid_o  (fq_valid),
    .q_stall_i  (fq_stall),
    .q_entry_o  (fq_entry)
  );

  // decouple the command side from the pixel side
  clr_queue #(
    .DATA_BITS (ENTRY_BITS),
    .DEPTH     (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fq_valid),
    .wr_stall_o (fq_stall),
    .wr_data_i  (fq_entry),
    .rd_valid_o (qb_valid),
    .rd_stall_i (qb_stall),
    .rd_data_o  (qb_entry)
  );

  // step the line and produce pixels
  clr_back #(
    .COORD_BITS (COORD_BITS),
    .ENTRY_BITS (ENTRY_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .q_valid_i       (qb_valid),
    .q_stall_o       (qb_stall),
    .q_entry_i       (qb_entry),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .pixel_x_o       (pixel_x_o),
    .pixel_y_o       (pixel_y_o),
    .pixel_address_o (pixel_address_o),
    .write_enable_o  (write_enable_o),
    .color_o         (color_o),
    .last_o          (last_o)
  );

endmodule

`default_nettype wire
